@@ rtl/assert_macros.svh @@
// assertion macros for files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/lhs_pkg.sv @@
// types, constants and helper functions of the latency histogram statistics block
package lhs_pkg;

  localparam int NUM_TYPES       = 15;
  localparam int NUM_BUCKETS     = 64;
  localparam int SUB_BUCKET_BITS = 1;

  localparam int NUM_CELLS = NUM_TYPES * NUM_BUCKETS;
  localparam int ADDR_W    = $clog2(NUM_CELLS);
  localparam int BKT_W     = $clog2(NUM_BUCKETS);
  localparam int TIDX_W    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int DIV_STEPS = 64;
  localparam int MUL_STEPS = 4;
  localparam int NUM_PCT   = 3;
  localparam int CTR_W     = ($clog2(NUM_CELLS + 1) > 7) ? $clog2(NUM_CELLS + 1) : 7;

  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DISABLED = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  type_index;
    logic [63:0] sample_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] sample_count;
    logic [63:0] average;
    logic [63:0] minimum;
    logic [63:0] maximum;
    logic [63:0] p90_value;
    logic [63:0] p99_value;
    logic [63:0] p9999_value;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_CLR, OP_REC_IDX, OP_REC_RD, OP_REC_WR,
    OP_AVG_LD, OP_DIV_STEP, OP_AVG_SV, OP_TGT_LO, OP_TGT_HI, OP_TGT_SUM,
    OP_WALK_RD, OP_WALK_CHK, OP_MD_PREP, OP_MUL_PP,
    OP_P_LOW, OP_P_SAT, OP_P_DIV, OP_P_LAST, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [CTR_W-1:0] ctr;
    logic [1:0]       pct;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       enable;
    logic       type_ok;
    logic       zero_sample;
    logic       cnt_zero;
    logic       hit;
    logic       bk_zero;
    logic       sat;
  } dp_sts_t;

  // percentile fraction and rounding term, in units of 2^-32
  function automatic logic [31:0] pct_frac(logic [1:0] p);
    case (p)
      2'd0:    return 32'd3865470566;
      2'd1:    return 32'd4252017623;
      default: return 32'd4294537799;
    endcase
  endfunction

  function automatic logic [31:0] pct_round(logic [1:0] p);
    case (p)
      2'd0:    return 32'd4252017623;
      2'd1:    return 32'd4290672329;
      default: return 32'd4294924346;
    endcase
  endfunction

  function automatic logic [63:0] lower_bound(logic [BKT_W:0] b);
    int unsigned e;
    int unsigned s;
    logic [63:0] base;
    e = int'(b) >> SUB_BUCKET_BITS;
    s = int'(b) & ((1 << SUB_BUCKET_BITS) - 1);
    if (b == '0) return 64'd0;
    if (e > 63) return '1;
    base = 64'd1 << e;
    if (e >= SUB_BUCKET_BITS) return base + (base >> SUB_BUCKET_BITS) * 64'(s);
    return base + ((base * 64'(s)) >> SUB_BUCKET_BITS);
  endfunction

  // bucket of a nonzero sample, saturated at the last bucket
  function automatic logic [BKT_W-1:0] bucket_of(logic [63:0] v);
    logic [5:0]  e;
    int unsigned base_i;
    int unsigned sub;
    logic [63:0] off;
    e = 6'd0;
    for (int i = 1; i < 64; i++) begin
      if (v[i]) e = 6'(i);
    end
    base_i = int'(e) << SUB_BUCKET_BITS;
    if (base_i >= NUM_BUCKETS) return BKT_W'(NUM_BUCKETS - 1);
    off = v - (64'd1 << e);
    if (int'(e) >= SUB_BUCKET_BITS) sub = int'(off >> (int'(e) - SUB_BUCKET_BITS));
    else sub = int'(off << (SUB_BUCKET_BITS - int'(e)));
    sub = sub & ((1 << SUB_BUCKET_BITS) - 1);
    base_i = base_i + sub;
    return (base_i >= NUM_BUCKETS) ? BKT_W'(NUM_BUCKETS - 1) : BKT_W'(base_i);
  endfunction

endpackage

@@ rtl/latency_histogram_stats_core.sv @@
// top level of the per-type latency statistics and histogram block
// One item is worked at a time; the next transfer is taken once the result is
// in the output register. A record steps through bucket index, memory read,
// memory write and result; an item that is rejected or ignored goes straight
// to the result, and a clear sweeps the bucket memory one entry a cycle. A
// query runs the average through the bit-serial divider, then for each of the
// three percentiles a bucket walk (one memory read per bucket) and, where
// needed, the 4-step multiply and 64-step divide of the interpolation. After
// reset the same clearing pass runs before the first item is taken; enable
// writes are accepted at any time.
`include "assert_macros.svh"

module latency_histogram_stats_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lhs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lhs_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data
);

  lhs_pkg::dp_cmd_t cmd;
  lhs_pkg::dp_sts_t sts;
  logic             cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  lhs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lhs_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .cmd      (cmd),
    .sts      (sts),
    .rsp      (rsp)
  );

  // a transfer in makes the block busy on the next cycle
  `ASSERT_NEXT(a_busy_after_take, clk, rst, req_valid && !req_stall, req_stall)
  // error results carry no statistics
  `ASSERT_IMPLIES(a_err_no_stats, clk, rst, rsp_valid && (rsp.status != lhs_pkg::ST_OK), (rsp.sample_count == 64'd0) && (rsp.maximum == 64'd0))
  // percentiles are clamped to the maximum
  `ASSERT_IMPLIES(a_pct_clamped, clk, rst, rsp_valid, (rsp.p90_value <= rsp.maximum) && (rsp.p99_value <= rsp.maximum) && (rsp.p9999_value <= rsp.maximum))

endmodule

@@ rtl/lhs_datapath.sv @@
// statistics registers, bucket memory, multiplier, divider and result register
module lhs_datapath (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_data,
  input  lhs_pkg::req_t   req,
  input  lhs_pkg::dp_cmd_t cmd,
  output lhs_pkg::dp_sts_t sts,
  output lhs_pkg::rsp_t   rsp
);

  logic                       enable;
  lhs_pkg::req_t              item;
  logic [lhs_pkg::ADDR_W-1:0] tbase;
  logic [lhs_pkg::BKT_W-1:0]  bidx;
  logic [lhs_pkg::ADDR_W-1:0] rec_addr;
  logic [63:0]                mem [lhs_pkg::NUM_CELLS];
  logic [63:0]                rd_data;
  logic [63:0]                cnt_a [lhs_pkg::NUM_TYPES];
  logic [63:0]                sum_a [lhs_pkg::NUM_TYPES];
  logic [63:0]                min_a [lhs_pkg::NUM_TYPES];
  logic [63:0]                max_a [lhs_pkg::NUM_TYPES];
  logic [63:0]                tlo;
  logic [63:0]                thi;
  logic [63:0]                q;
  logic [63:0]                cum;
  logic [63:0]                prior_cum;
  logic [63:0]                bk;
  logic [lhs_pkg::BKT_W-1:0]  walk_b;
  logic [63:0]                low;
  logic [63:0]                ma;
  logic [63:0]                mb;
  logic [127:0]               prod;
  logic [63:0]                den;
  logic [63:0]                avg;
  logic [63:0]                pres [lhs_pkg::NUM_PCT];

  logic [lhs_pkg::ADDR_W-1:0] mem_addr;
  logic                       mem_we;
  logic                       mem_re;
  logic [63:0]                mem_wd;
  logic [lhs_pkg::TIDX_W-1:0] tsel;
  logic                       type_ok;
  logic [63:0]                cur_cnt;
  logic [63:0]                cur_sum;
  logic [63:0]                cur_min;
  logic [63:0]                cur_max;
  logic [63:0]                cum_next;
  logic [63:0]                rem;
  logic [63:0]                rem_sh;
  logic                       take;
  logic [31:0]                pa;
  logic [31:0]                pb;
  logic [63:0]                pp;
  logic [127:0]               pp_sh;
  logic [63:0]                lb_lo;
  logic [63:0]                lb_hi;
  logic [63:0]                p_val;
  logic [63:0]                p_clamped;
  logic                       qok;
  lhs_pkg::rsp_t              built;

  assign tsel    = lhs_pkg::TIDX_W'(item.type_index);
  assign type_ok = int'(item.type_index) < lhs_pkg::NUM_TYPES;
  assign cur_cnt = cnt_a[tsel];
  assign cur_sum = sum_a[tsel];
  assign cur_min = min_a[tsel];
  assign cur_max = max_a[tsel];

  always_comb begin
    case (cmd.op)
      lhs_pkg::OP_CLR:     mem_addr = lhs_pkg::ADDR_W'(cmd.ctr);
      lhs_pkg::OP_REC_RD:  mem_addr = tbase + lhs_pkg::ADDR_W'(bidx);
      lhs_pkg::OP_WALK_RD: mem_addr = tbase + lhs_pkg::ADDR_W'(cmd.ctr[lhs_pkg::BKT_W-1:0]);
      default:             mem_addr = rec_addr;
    endcase
  end

  assign mem_we = (cmd.op == lhs_pkg::OP_CLR) || (cmd.op == lhs_pkg::OP_REC_WR);
  assign mem_re = (cmd.op == lhs_pkg::OP_REC_RD) || (cmd.op == lhs_pkg::OP_WALK_RD);
  assign mem_wd = (cmd.op == lhs_pkg::OP_CLR) ? 64'd0 : rd_data + 64'd1;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    if (mem_re) rd_data <= mem[mem_addr];
  end

  // restoring division step on the {rem, lo} pair, quotient shifts into lo
  assign rem    = prod[127:64];
  assign rem_sh = {rem[62:0], prod[63]};
  assign take   = rem[63] || (rem_sh >= den);

  assign cum_next = cum + rd_data;

  // partial products: al*bl, al*bh, ah*bl, ah*bh
  assign pa    = cmd.ctr[1] ? ma[63:32] : ma[31:0];
  assign pb    = cmd.ctr[0] ? mb[63:32] : mb[31:0];
  assign pp    = 64'(pa) * 64'(pb);
  assign pp_sh = {64'd0, pp} << (32 * (int'(cmd.ctr[1]) + int'(cmd.ctr[0])));

  assign lb_lo = lhs_pkg::lower_bound({1'b0, walk_b});
  assign lb_hi = lhs_pkg::lower_bound({1'b0, walk_b} + (lhs_pkg::BKT_W + 1)'(1));

  always_comb begin
    case (cmd.op)
      lhs_pkg::OP_P_LOW: p_val = low;
      lhs_pkg::OP_P_SAT: p_val = low + 64'hFFFF_FFFF_FFFF_FFFF;
      lhs_pkg::OP_P_DIV: p_val = low + prod[63:0];
      default:           p_val = lhs_pkg::lower_bound((lhs_pkg::BKT_W + 1)'(lhs_pkg::NUM_BUCKETS - 1));
    endcase
  end
  assign p_clamped = (p_val < cur_max) ? p_val : cur_max;

  assign qok = (item.mode == lhs_pkg::MODE_QUERY) && type_ok && (cur_cnt != 64'd0);

  always_comb begin
    built = '0;
    if (item.mode == lhs_pkg::MODE_RECORD) begin
      if (!enable) built.status = lhs_pkg::ST_DISABLED;
      else if (!type_ok) built.status = lhs_pkg::ST_BAD_TYPE;
      else built.status = lhs_pkg::ST_OK;
    end else if (item.mode == lhs_pkg::MODE_QUERY) begin
      built.status = type_ok ? lhs_pkg::ST_OK : lhs_pkg::ST_BAD_TYPE;
    end else begin
      built.status = lhs_pkg::ST_OK;
    end
    if (qok) begin
      built.sample_count = cur_cnt;
      built.average      = avg;
      built.minimum      = cur_min;
      built.maximum      = cur_max;
      built.p90_value    = pres[0];
      built.p99_value    = pres[1];
      built.p9999_value  = pres[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
      for (int i = 0; i < lhs_pkg::NUM_TYPES; i++) begin
        cnt_a[i] <= 64'd0;
        sum_a[i] <= 64'd0;
        min_a[i] <= '1;
        max_a[i] <= 64'd0;
      end
    end else begin
      if (cfg_we) enable <= cfg_data;
      case (cmd.op)
        lhs_pkg::OP_LATCH: begin
          item  <= req;
          tbase <= lhs_pkg::ADDR_W'(int'(req.type_index) * lhs_pkg::NUM_BUCKETS);
        end
        lhs_pkg::OP_CLR: begin
          for (int i = 0; i < lhs_pkg::NUM_TYPES; i++) begin
            cnt_a[i] <= 64'd0;
            sum_a[i] <= 64'd0;
            min_a[i] <= '1;
            max_a[i] <= 64'd0;
          end
        end
        lhs_pkg::OP_REC_IDX: bidx <= lhs_pkg::bucket_of(item.sample_value);
        lhs_pkg::OP_REC_RD:  rec_addr <= mem_addr;
        lhs_pkg::OP_REC_WR: begin
          cnt_a[tsel] <= cur_cnt + 64'd1;
          sum_a[tsel] <= cur_sum + item.sample_value;
          if (item.sample_value < cur_min) min_a[tsel] <= item.sample_value;
          if (item.sample_value > cur_max) max_a[tsel] <= item.sample_value;
        end
        lhs_pkg::OP_AVG_LD: begin
          prod <= {64'd0, cur_sum};
          den  <= cur_cnt;
        end
        lhs_pkg::OP_DIV_STEP: begin
          prod <= {(take ? rem_sh - den : rem_sh), prod[62:0], take};
        end
        lhs_pkg::OP_AVG_SV: avg <= prod[63:0];
        lhs_pkg::OP_TGT_LO: begin
          tlo <= 64'(cur_cnt[31:0]) * 64'(lhs_pkg::pct_frac(cmd.pct))
                 + 64'(lhs_pkg::pct_round(cmd.pct));
        end
        lhs_pkg::OP_TGT_HI: thi <= 64'(cur_cnt[63:32]) * 64'(lhs_pkg::pct_frac(cmd.pct));
        lhs_pkg::OP_TGT_SUM: begin
          q         <= thi + (tlo >> 32);
          cum       <= 64'd0;
          prior_cum <= 64'd0;
        end
        lhs_pkg::OP_WALK_CHK: begin
          prior_cum <= cum;
          cum       <= cum_next;
          bk        <= rd_data;
          walk_b    <= cmd.ctr[lhs_pkg::BKT_W-1:0];
        end
        lhs_pkg::OP_MD_PREP: begin
          low  <= lb_lo;
          ma   <= q - prior_cum;
          mb   <= lb_hi - lb_lo;
          prod <= '0;
          den  <= bk;
        end
        lhs_pkg::OP_MUL_PP: prod <= prod + pp_sh;
        lhs_pkg::OP_P_LOW, lhs_pkg::OP_P_SAT, lhs_pkg::OP_P_DIV, lhs_pkg::OP_P_LAST: begin
          pres[cmd.pct] <= p_clamped;
        end
        lhs_pkg::OP_EMIT: rsp <= built;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sts.mode        = item.mode;
    sts.enable      = enable;
    sts.type_ok     = type_ok;
    sts.zero_sample = item.sample_value == 64'd0;
    sts.cnt_zero    = cur_cnt == 64'd0;
    sts.hit         = cum_next >= q;
    sts.bk_zero     = bk == 64'd0;
    sts.sat         = prod[127:64] >= den;
  end

endmodule

@@ rtl/lhs_ctrl.sv @@
// sequencer that steps the datapath through record, query and clear work
module lhs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  input  lhs_pkg::dp_sts_t sts,
  output lhs_pkg::dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DECODE, S_REC_IDX, S_REC_RD, S_REC_WR,
    S_AVG_LD, S_DIV, S_AVG_SV, S_TGT_LO, S_TGT_HI, S_TGT_SUM,
    S_WALK_RD, S_WALK_CHK, S_MD_PREP, S_MUL, S_SAT_CHK,
    S_P_LOW, S_P_SAT, S_P_DIV, S_P_LAST, S_EMIT
  } state_t;

  state_t                    state;
  logic [lhs_pkg::CTR_W-1:0] ctr;
  logic [1:0]                pct;
  logic                      div_pct;
  logic                      clr_item;
  logic                      rsp_free;

  assign req_stall = state != S_IDLE;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    cmd.ctr = ctr;
    cmd.pct = pct;
    case (state)
      S_INIT:     cmd.op = lhs_pkg::OP_CLR;
      S_IDLE:     cmd.op = req_valid ? lhs_pkg::OP_LATCH : lhs_pkg::OP_NONE;
      S_REC_IDX:  cmd.op = lhs_pkg::OP_REC_IDX;
      S_REC_RD:   cmd.op = lhs_pkg::OP_REC_RD;
      S_REC_WR:   cmd.op = lhs_pkg::OP_REC_WR;
      S_AVG_LD:   cmd.op = lhs_pkg::OP_AVG_LD;
      S_DIV:      cmd.op = lhs_pkg::OP_DIV_STEP;
      S_AVG_SV:   cmd.op = lhs_pkg::OP_AVG_SV;
      S_TGT_LO:   cmd.op = lhs_pkg::OP_TGT_LO;
      S_TGT_HI:   cmd.op = lhs_pkg::OP_TGT_HI;
      S_TGT_SUM:  cmd.op = lhs_pkg::OP_TGT_SUM;
      S_WALK_RD:  cmd.op = lhs_pkg::OP_WALK_RD;
      S_WALK_CHK: cmd.op = lhs_pkg::OP_WALK_CHK;
      S_MD_PREP:  cmd.op = lhs_pkg::OP_MD_PREP;
      S_MUL:      cmd.op = lhs_pkg::OP_MUL_PP;
      S_P_LOW:    cmd.op = lhs_pkg::OP_P_LOW;
      S_P_SAT:    cmd.op = lhs_pkg::OP_P_SAT;
      S_P_DIV:    cmd.op = lhs_pkg::OP_P_DIV;
      S_P_LAST:   cmd.op = lhs_pkg::OP_P_LAST;
      S_EMIT:     cmd.op = rsp_free ? lhs_pkg::OP_EMIT : lhs_pkg::OP_NONE;
      default:    cmd.op = lhs_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      ctr       <= '0;
      pct       <= 2'd0;
      div_pct   <= 1'b0;
      clr_item  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // the emit state loads the next result itself
      if (rsp_valid && !rsp_stall && (state != S_EMIT)) rsp_valid <= 1'b0;
      case (state)
        S_INIT: begin
          if (ctr == lhs_pkg::CTR_W'(lhs_pkg::NUM_CELLS - 1)) begin
            ctr      <= '0;
            clr_item <= 1'b0;
            state    <= clr_item ? S_EMIT : S_IDLE;
          end else begin
            ctr <= ctr + 1'b1;
          end
        end
        S_IDLE: begin
          if (req_valid) state <= S_DECODE;
        end
        S_DECODE: begin
          case (sts.mode)
            lhs_pkg::MODE_RECORD: begin
              if (!sts.enable || !sts.type_ok || sts.zero_sample) state <= S_EMIT;
              else state <= S_REC_IDX;
            end
            lhs_pkg::MODE_QUERY: begin
              if (!sts.type_ok || sts.cnt_zero) state <= S_EMIT;
              else state <= S_AVG_LD;
            end
            lhs_pkg::MODE_CLEAR: begin
              clr_item <= 1'b1;
              ctr      <= '0;
              state    <= S_INIT;
            end
            default: state <= S_EMIT;
          endcase
        end
        S_REC_IDX: state <= S_REC_RD;
        S_REC_RD:  state <= S_REC_WR;
        S_REC_WR:  state <= S_EMIT;
        S_AVG_LD: begin
          ctr     <= '0;
          div_pct <= 1'b0;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (ctr == lhs_pkg::CTR_W'(lhs_pkg::DIV_STEPS - 1)) begin
            ctr   <= '0;
            state <= div_pct ? S_P_DIV : S_AVG_SV;
          end else begin
            ctr <= ctr + 1'b1;
          end
        end
        S_AVG_SV: begin
          pct   <= 2'd0;
          state <= S_TGT_LO;
        end
        S_TGT_LO: state <= S_TGT_HI;
        S_TGT_HI: state <= S_TGT_SUM;
        S_TGT_SUM: begin
          ctr   <= '0;
          state <= S_WALK_RD;
        end
        S_WALK_RD: state <= S_WALK_CHK;
        S_WALK_CHK: begin
          if (sts.hit) begin
            state <= S_MD_PREP;
          end else if (ctr == lhs_pkg::CTR_W'(lhs_pkg::NUM_BUCKETS - 1)) begin
            state <= S_P_LAST;
          end else begin
            ctr   <= ctr + 1'b1;
            state <= S_WALK_RD;
          end
        end
        S_MD_PREP: begin
          ctr   <= '0;
          state <= sts.bk_zero ? S_P_LOW : S_MUL;
        end
        S_MUL: begin
          if (ctr == lhs_pkg::CTR_W'(lhs_pkg::MUL_STEPS - 1)) begin
            ctr   <= '0;
            state <= S_SAT_CHK;
          end else begin
            ctr <= ctr + 1'b1;
          end
        end
        S_SAT_CHK: begin
          if (sts.sat) begin
            state <= S_P_SAT;
          end else begin
            div_pct <= 1'b1;
            ctr     <= '0;
            state   <= S_DIV;
          end
        end
        S_P_LOW, S_P_SAT, S_P_DIV, S_P_LAST: begin
          if (pct == 2'(lhs_pkg::NUM_PCT - 1)) begin
            state <= S_EMIT;
          end else begin
            pct   <= pct + 2'd1;
            state <= S_TGT_LO;
          end
        end
        S_EMIT: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/sv/tb_latency_histogram_stats_core.sv @@
// self-checking bench for the latency histogram statistics core
module tb_latency_histogram_stats_core;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 900;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  lhs_pkg::req_t  req;
  logic           rsp_valid;
  logic           rsp_stall;
  lhs_pkg::rsp_t  rsp;
  logic           cfg_valid;
  logic           cfg_ready;
  logic           cfg_data;
  logic           req_fire;

  latency_histogram_stats_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // shadow statistics
  logic        hist_enable;
  logic [63:0] hist_bins [lhs_pkg::NUM_TYPES][lhs_pkg::NUM_BUCKETS];
  logic [63:0] hist_count [lhs_pkg::NUM_TYPES];
  logic [63:0] hist_sum [lhs_pkg::NUM_TYPES];
  logic [63:0] hist_min [lhs_pkg::NUM_TYPES];
  logic [63:0] hist_max [lhs_pkg::NUM_TYPES];

  lhs_pkg::req_t pending_reqs[$];
  lhs_pkg::rsp_t expected_rsps[$];

  int  error_count;
  int  req_done;
  int  rsp_done;
  int  query_hits;
  int  idle_cycles;
  int  req_gap;
  int  rsp_gap;
  bit  calm_phase;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void wipe_stats();
    for (int t = 0; t < lhs_pkg::NUM_TYPES; t++) begin
      for (int b = 0; b < lhs_pkg::NUM_BUCKETS; b++) hist_bins[t][b] = '0;
      hist_count[t] = '0;
      hist_sum[t]   = '0;
      hist_min[t]   = '1;
      hist_max[t]   = '0;
    end
  endfunction

  function automatic int sample_bucket(logic [63:0] v);
    int e;
    int idx;
    e = 0;
    for (int i = 0; i < 64; i++) if (v[i]) e = i;
    idx = e << lhs_pkg::SUB_BUCKET_BITS;
    if (idx >= lhs_pkg::NUM_BUCKETS) return lhs_pkg::NUM_BUCKETS - 1;
    if (e >= lhs_pkg::SUB_BUCKET_BITS)
      idx += int'((v >> (e - lhs_pkg::SUB_BUCKET_BITS)) & 1);
    else
      idx += int'((v << (lhs_pkg::SUB_BUCKET_BITS - e)) & 1);
    return (idx >= lhs_pkg::NUM_BUCKETS) ? lhs_pkg::NUM_BUCKETS - 1 : idx;
  endfunction

  function automatic logic [63:0] bucket_floor(int b);
    int e;
    logic [63:0] base;
    if (b == 0) return '0;
    e = b >> lhs_pkg::SUB_BUCKET_BITS;
    if (e > 63) return '1;
    base = 64'd1 << e;
    if (b % 2 == 1) return base + (base >> 1);
    return base;
  endfunction

  function automatic logic [63:0] pct_point(int t, logic [63:0] cnt,
                                            logic [31:0] frac, logic [31:0] rnd);
    logic [127:0] tgt;
    logic [63:0]  goal;
    logic [63:0]  cum;
    logic [63:0]  prior;
    logic [63:0]  lo;
    logic [127:0] span;
    int b;
    tgt  = 128'(cnt) * 128'(frac) + 128'(rnd);
    goal = tgt[95:32];
    cum  = '0;
    prior = '0;
    for (b = 0; b < lhs_pkg::NUM_BUCKETS; b++) begin
      prior = cum;
      cum   = cum + hist_bins[t][b];
      if (cum >= goal) break;
    end
    if (b >= lhs_pkg::NUM_BUCKETS) return bucket_floor(lhs_pkg::NUM_BUCKETS - 1);
    lo = bucket_floor(b);
    if (hist_bins[t][b] == 0) return lo;
    span = 128'(goal - prior) * 128'(bucket_floor(b + 1) - lo)
           / 128'(hist_bins[t][b]);
    if (span[127:64] != 0) return lo + 64'hFFFF_FFFF_FFFF_FFFF;
    return lo + span[63:0];
  endfunction

  function automatic lhs_pkg::rsp_t predict_stats(lhs_pkg::req_t r);
    lhs_pkg::rsp_t o;
    int b;
    logic [63:0] mx;
    logic [63:0] p;
    o = '0;
    case (r.mode)
      lhs_pkg::MODE_RECORD: begin
        if (!hist_enable) o.status = lhs_pkg::ST_DISABLED;
        else if (r.type_index >= lhs_pkg::NUM_TYPES) o.status = lhs_pkg::ST_BAD_TYPE;
        else if (r.sample_value != 0) begin
          b = sample_bucket(r.sample_value);
          hist_bins[r.type_index][b] += 1;
          hist_count[r.type_index] += 1;
          hist_sum[r.type_index] += r.sample_value;
          if (r.sample_value < hist_min[r.type_index])
            hist_min[r.type_index] = r.sample_value;
          if (r.sample_value > hist_max[r.type_index])
            hist_max[r.type_index] = r.sample_value;
        end
      end
      lhs_pkg::MODE_QUERY: begin
        if (r.type_index >= lhs_pkg::NUM_TYPES) o.status = lhs_pkg::ST_BAD_TYPE;
        else if (hist_count[r.type_index] != 0) begin
          mx = hist_max[r.type_index];
          o.sample_count = hist_count[r.type_index];
          o.average = hist_sum[r.type_index] / hist_count[r.type_index];
          o.minimum = hist_min[r.type_index];
          o.maximum = mx;
          p = pct_point(r.type_index, o.sample_count, lhs_pkg::pct_frac(2'd0),
                        lhs_pkg::pct_round(2'd0));
          o.p90_value = (p < mx) ? p : mx;
          p = pct_point(r.type_index, o.sample_count, lhs_pkg::pct_frac(2'd1),
                        lhs_pkg::pct_round(2'd1));
          o.p99_value = (p < mx) ? p : mx;
          p = pct_point(r.type_index, o.sample_count, lhs_pkg::pct_frac(2'd2),
                        lhs_pkg::pct_round(2'd2));
          o.p9999_value = (p < mx) ? p : mx;
        end
      end
      lhs_pkg::MODE_CLEAR: wipe_stats();
      default: ;
    endcase
    return o;
  endfunction

  function automatic lhs_pkg::req_t make_req(logic [1:0] m, int t, logic [63:0] v);
    lhs_pkg::req_t r;
    r.mode = m;
    r.type_index = 4'(t);
    r.sample_value = v;
    return r;
  endfunction

  function automatic logic [63:0] random_latency();
    logic [63:0] v;
    int w;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: w = 64;
      1: w = $urandom_range(33, 63);
      default: w = $urandom_range(1, 20);
    endcase
    if (w < 64) v = v & ((64'd1 << w) - 1);
    return v;
  endfunction

  // request transfer seen at the last rising edge
  always @(posedge clk) begin
    req_fire <= !rst && req_valid && !req_stall;
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (req_gap > 0 && !calm_phase) begin
        req_gap <= req_gap - 1;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
        if (!calm_phase && $urandom_range(0, 9) == 0) req_gap <= $urandom_range(1, 18);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response stall pattern
  always @(negedge clk) begin
    if (rst || calm_phase) begin
      rsp_stall <= 1'b0;
    end else if (rsp_gap > 0) begin
      rsp_gap <= rsp_gap - 1;
      rsp_stall <= 1'b1;
    end else if ($urandom_range(0, 15) == 0) begin
      rsp_gap <= $urandom_range(0, 17);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // monitor: predicts on request transfer, checks on response transfer
  always @(posedge clk) begin : monitor
    lhs_pkg::rsp_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(predict_stats(req));
        req_done++;
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_done++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response %h", $time, rsp);
          error_count++;
        end else begin
          want = expected_rsps.pop_front();
          if (want.sample_count != 0) query_hits++;
          if (rsp.status !== want.status)
            $display("%0t: status exp %0d got %0d", $time, want.status, rsp.status);
          if (rsp.sample_count !== want.sample_count)
            $display("%0t: count exp %0d got %0d", $time, want.sample_count,
                     rsp.sample_count);
          if (rsp.average !== want.average)
            $display("%0t: average exp %0d got %0d", $time, want.average, rsp.average);
          if (rsp.minimum !== want.minimum)
            $display("%0t: minimum exp %0d got %0d", $time, want.minimum, rsp.minimum);
          if (rsp.maximum !== want.maximum)
            $display("%0t: maximum exp %0d got %0d", $time, want.maximum, rsp.maximum);
          if (rsp.p90_value !== want.p90_value)
            $display("%0t: p90 exp %0d got %0d", $time, want.p90_value, rsp.p90_value);
          if (rsp.p99_value !== want.p99_value)
            $display("%0t: p99 exp %0d got %0d", $time, want.p99_value, rsp.p99_value);
          if (rsp.p9999_value !== want.p9999_value)
            $display("%0t: p99.99 exp %0d got %0d", $time, want.p9999_value,
                     rsp.p9999_value);
          if (rsp !== want) error_count++;
        end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d responses outstanding", expected_rsps.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic write_enable(logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    hist_enable = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_valid)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int t;
    for (int i = 0; i < n; i++) begin
      t = $urandom_range(0, 14);
      case ($urandom_range(0, 39))
        0: pending_reqs.push_back(make_req(lhs_pkg::MODE_CLEAR, $urandom_range(0, 15),
                                           random_latency()));
        1: pending_reqs.push_back(make_req(MODE_UNUSED, $urandom_range(0, 15),
                                           random_latency()));
        2: pending_reqs.push_back(make_req(lhs_pkg::MODE_RECORD, 15, random_latency()));
        3: pending_reqs.push_back(make_req(lhs_pkg::MODE_QUERY, 15, random_latency()));
        4: pending_reqs.push_back(make_req(lhs_pkg::MODE_RECORD, t, 64'd0));
        5, 6, 7, 8:
          pending_reqs.push_back(make_req(lhs_pkg::MODE_QUERY, t, random_latency()));
        default: pending_reqs.push_back(make_req(lhs_pkg::MODE_RECORD, t, random_latency()));
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    error_count = 0;
    req_done = 0;
    rsp_done = 0;
    query_hits = 0;
    idle_cycles = 0;
    req_gap = 0;
    rsp_gap = 0;
    calm_phase = 1'b0;
    hist_enable = 1'b0;
    wipe_stats();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // disabled: records rejected, query/clear still work
    pending_reqs.push_back(make_req(lhs_pkg::MODE_RECORD, 0, 64'd5));
    pending_reqs.push_back(make_req(lhs_pkg::MODE_QUERY, 0, 64'd0));
    pending_reqs.push_back(make_req(lhs_pkg::MODE_CLEAR, 3, 64'd0));
    drain();
    write_enable(1'b1);
    pending_reqs.push_back(make_req(lhs_pkg::MODE_RECORD, 0, 64'd1));
    pending_reqs.push_back(make_req(lhs_pkg::MODE_RECORD, 0, 64'd2));
    pending_reqs.push_back(make_req(lhs_pkg::MODE_RECORD, 0, 64'd3));
    pending_reqs.push_back(make_req(lhs_pkg::MODE_RECORD, 0, '1));
    pending_reqs.push_back(make_req(lhs_pkg::MODE_RECORD, 0, 64'h8000_0000_0000_0000));
    pending_reqs.push_back(make_req(lhs_pkg::MODE_RECORD, 0, 64'h0000_0001_8000_0000));
    pending_reqs.push_back(make_req(lhs_pkg::MODE_RECORD, 0, 64'd0));
    pending_reqs.push_back(make_req(lhs_pkg::MODE_RECORD, 15, 64'd7));
    pending_reqs.push_back(make_req(lhs_pkg::MODE_QUERY, 15, 64'd0));
    pending_reqs.push_back(make_req(lhs_pkg::MODE_QUERY, 14, 64'd0));
    pending_reqs.push_back(make_req(lhs_pkg::MODE_RECORD, 14, 64'd1000));
    pending_reqs.push_back(make_req(lhs_pkg::MODE_QUERY, 14, 64'd0));
    pending_reqs.push_back(make_req(lhs_pkg::MODE_QUERY, 0, '1));
    pending_reqs.push_back(make_req(MODE_UNUSED, 15, '1));
    pending_reqs.push_back(make_req(lhs_pkg::MODE_CLEAR, 0, 64'd0));
    pending_reqs.push_back(make_req(lhs_pkg::MODE_QUERY, 0, 64'd0));
    drain();

    random_phase(RANDOM_ITEMS / 3);
    drain();
    write_enable(1'b0);
    random_phase(60);
    drain();
    write_enable(1'b1);
    random_phase(RANDOM_ITEMS / 3);
    drain();
    calm_phase = 1'b1;
    random_phase(RANDOM_ITEMS / 3);
    drain();

    $display("%0d requests sent, %0d responses checked, %0d queries with data",
             req_done, rsp_done, query_hits);
    $display("covered enable on and off, clears, bad types, zero and extreme samples");
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lhs_pkg.sv
rtl/lhs_datapath.sv
rtl/lhs_ctrl.sv
rtl/latency_histogram_stats_core.sv
tb/sv/tb_latency_histogram_stats_core.sv
